@@ design/ubx_enc_pkg.sv @@
package ubx_enc_pkg;

   localparam int ByteW    = 8;
   localparam int LenW     = 16;
   localparam int MaxBurst = 8;
   localparam int CntW     = $clog2(MaxBurst + 1);
   localparam int CsrIdxW  = 8;

   localparam logic CMD_START   = 1'b0;
   localparam logic CMD_PAYLOAD = 1'b1;

   localparam logic [CsrIdxW-1:0] CSR_SYNC_FIRST  = CsrIdxW'(0);
   localparam logic [CsrIdxW-1:0] CSR_SYNC_SECOND = CsrIdxW'(1);

   localparam logic [ByteW-1:0] SYNC_FIRST_RESET  = 8'd181;
   localparam logic [ByteW-1:0] SYNC_SECOND_RESET = 8'd98;

   localparam logic [CntW-1:0] HEADER_COUNT        = CntW'(6);
   localparam logic [CntW-1:0] HEADER_TRAILER_COUNT = CntW'(8);
   localparam logic [CntW-1:0] BYTE_COUNT          = CntW'(1);
   localparam logic [CntW-1:0] BYTE_TRAILER_COUNT  = CntW'(3);

   typedef struct packed {
      logic             command;
      logic [ByteW-1:0] msg_class;
      logic [ByteW-1:0] msg_id;
      logic [LenW-1:0]  payload_length;
      logic [ByteW-1:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [ByteW-1:0] out_byte;
      logic             frame_end;
      logic             run_last;
   } rsp_type;

   typedef struct packed {
      logic [MaxBurst-1:0][ByteW-1:0] bytes;
      logic [CntW-1:0]                count;
      logic                           trailer;
   } burst_type;

endpackage

@@ design/ubx_enc_core.sv @@
module ubx_enc_core
   import ubx_enc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   input  logic [ByteW-1:0] sync_first,
   input  logic [ByteW-1:0] sync_second,
   input  logic             burst_free,
   output logic             burst_load,
   output burst_type        burst
);

   logic             item_valid_ff, item_valid_in;
   req_type          item_ff, item_in;
   logic [ByteW-1:0] sum_a_ff, sum_a_in;
   logic [ByteW-1:0] sum_b_ff, sum_b_in;
   logic [LenW-1:0]  bytes_left_ff, bytes_left_in;
   logic             frame_open_ff, frame_open_in;
   logic             take;

   logic [ByteW-1:0] len_lo, len_hi;
   logic [ByteW-1:0] a1, a2, a3, a4, b2, b3, b4;
   logic [ByteW-1:0] pa, pb;
   logic [LenW-1:0]  left_dec;

   assign take      = item_valid_ff && burst_free;
   assign req_ready = !item_valid_ff || take;

   assign len_lo   = item_ff.payload_length[ByteW-1:0];
   assign len_hi   = item_ff.payload_length[LenW-1:ByteW];
   assign a1       = item_ff.msg_class;
   assign a2       = a1 + item_ff.msg_id;
   assign b2       = a1 + a2;
   assign a3       = a2 + len_lo;
   assign b3       = b2 + a3;
   assign a4       = a3 + len_hi;
   assign b4       = b3 + a4;
   assign pa       = sum_a_ff + item_ff.data_byte;
   assign pb       = sum_b_ff + pa;
   assign left_dec = bytes_left_ff - LenW'(1);

   always_comb begin
      item_valid_in = item_valid_ff;
      item_in       = item_ff;
      sum_a_in      = sum_a_ff;
      sum_b_in      = sum_b_ff;
      bytes_left_in = bytes_left_ff;
      frame_open_in = frame_open_ff;
      burst_load    = 1'b0;
      burst         = '0;
      if (take) begin
         item_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         item_valid_in = 1'b1;
         item_in       = req_data;
      end
      if (take) begin
         if (item_ff.command == CMD_START) begin
            burst_load     = 1'b1;
            burst.bytes[0] = sync_first;
            burst.bytes[1] = sync_second;
            burst.bytes[2] = item_ff.msg_class;
            burst.bytes[3] = item_ff.msg_id;
            burst.bytes[4] = len_lo;
            burst.bytes[5] = len_hi;
            burst.bytes[6] = a4;
            burst.bytes[7] = b4;
            burst.trailer  = (item_ff.payload_length == '0);
            burst.count    = burst.trailer ? HEADER_TRAILER_COUNT : HEADER_COUNT;
            sum_a_in       = a4;
            sum_b_in       = b4;
            bytes_left_in  = item_ff.payload_length;
            frame_open_in  = !burst.trailer;
         end else if (frame_open_ff && bytes_left_ff != '0) begin
            burst_load     = 1'b1;
            burst.bytes[0] = item_ff.data_byte;
            burst.bytes[1] = pa;
            burst.bytes[2] = pb;
            burst.trailer  = (left_dec == '0);
            burst.count    = burst.trailer ? BYTE_TRAILER_COUNT : BYTE_COUNT;
            sum_a_in       = pa;
            sum_b_in       = pb;
            bytes_left_in  = left_dec;
            frame_open_in  = !burst.trailer;
         end else begin
            frame_open_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         sum_a_ff      <= '0;
         sum_b_ff      <= '0;
         bytes_left_ff <= '0;
         frame_open_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         sum_a_ff      <= sum_a_in;
         sum_b_ff      <= sum_b_in;
         bytes_left_ff <= bytes_left_in;
         frame_open_ff <= frame_open_in;
      end
      item_ff <= item_in;
   end

endmodule

@@ design/ubx_enc_ser.sv @@
module ubx_enc_ser
   import ubx_enc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      burst_load,
   input  burst_type burst,
   output logic      burst_free,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_data
);

   logic                           valid_ff, valid_in;
   logic [MaxBurst-1:0][ByteW-1:0] bytes_ff, bytes_in;
   logic [CntW-1:0]                remain_ff, remain_in;
   logic                           trailer_ff, trailer_in;
   logic                           pop, last;

   assign last       = (remain_ff == CntW'(1));
   assign pop        = valid_ff && rsp_ready;
   assign burst_free = !valid_ff || (pop && last);

   assign rsp_valid          = valid_ff;
   assign rsp_data.out_byte  = bytes_ff[0];
   assign rsp_data.run_last  = last;
   assign rsp_data.frame_end = last && trailer_ff;

   always_comb begin
      valid_in   = valid_ff;
      bytes_in   = bytes_ff;
      remain_in  = remain_ff;
      trailer_in = trailer_ff;
      if (burst_load) begin
         valid_in   = 1'b1;
         bytes_in   = burst.bytes;
         remain_in  = burst.count;
         trailer_in = burst.trailer;
      end else if (pop) begin
         valid_in  = !last;
         bytes_in  = {ByteW'(0), bytes_ff[MaxBurst-1:1]};
         remain_in = remain_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         remain_ff <= '0;
      end else begin
         valid_ff  <= valid_in;
         remain_ff <= remain_in;
      end
      bytes_ff   <= bytes_in;
      trailer_ff <= trailer_in;
   end

endmodule

@@ design/ubx_frame_encoder.sv @@
// An accepted item waits in the input register until the byte shifter is free,
// is then loaded into the shifter, and the shifter shows its first byte on rsp_valid.
// Throughput: one item per cycle for payload items that give one byte, while
// rsp_ready stays high; an item giving more than one byte keeps the byte shifter busy,
// and the next item waits in the input register until the last of its bytes is taken.
// Reset (synchronous, active high) closes any open frame, clears the checksum
// and count, drops pending bytes and restores the sync bytes to 0xB5 and 0x62.
module ubx_frame_encoder
   import ubx_enc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [ByteW-1:0]   csr_wdata
);

   logic [ByteW-1:0] sync_first_ff, sync_first_in;
   logic [ByteW-1:0] sync_second_ff, sync_second_in;
   logic             burst_load, burst_free;
   burst_type        burst;

   assign csr_ready = 1'b1;

   always_comb begin
      sync_first_in  = sync_first_ff;
      sync_second_in = sync_second_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SYNC_FIRST:  sync_first_in  = csr_wdata;
            CSR_SYNC_SECOND: sync_second_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= SYNC_FIRST_RESET;
         sync_second_ff <= SYNC_SECOND_RESET;
      end else begin
         sync_first_ff  <= sync_first_in;
         sync_second_ff <= sync_second_in;
      end
   end

   ubx_enc_core u_core (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .sync_first  (sync_first_ff),
      .sync_second (sync_second_ff),
      .burst_free  (burst_free),
      .burst_load  (burst_load),
      .burst       (burst)
   );

   ubx_enc_ser u_ser (
      .clock      (clock),
      .reset      (reset),
      .burst_load (burst_load),
      .burst      (burst),
      .burst_free (burst_free),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_end |-> rsp_data.run_last)
      else $error("frame_end without run_last");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      burst_load |-> burst_free)
      else $error("burst loaded while shifter busy");

   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.run_last |=> rsp_valid)
      else $error("burst cut short");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result pending after reset");

endmodule

@@ sim/tb_ubx_frame_encoder.sv @@
module tb_ubx_frame_encoder;
   import ubx_enc_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT   = 2000;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   req_type            req_data;
   logic               rsp_valid;
   logic               rsp_ready;
   rsp_type            rsp_data;
   logic               csr_valid;
   logic               csr_ready;
   logic [CsrIdxW-1:0] csr_index;
   logic [ByteW-1:0]   csr_wdata;

   int send_idle_pct = 19;
   int rsp_idle_pct  = 54;
   int errors        = 0;
   int stall_cycles  = 0;

   // encoder image
   logic [ByteW-1:0] sync_first  = SYNC_FIRST_RESET;
   logic [ByteW-1:0] sync_second = SYNC_SECOND_RESET;
   logic [ByteW-1:0] sum_a = '0;
   logic [ByteW-1:0] sum_b = '0;
   logic [LenW-1:0]  bytes_left = '0;
   logic             frame_open = 1'b0;
   rsp_type          frame_bytes_due[$];

   ubx_frame_encoder u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic void fold(logic [ByteW-1:0] x);
      sum_a = sum_a + x;
      sum_b = sum_b + sum_a;
   endfunction

   function automatic void emit(logic [ByteW-1:0] b, logic fe, logic rl);
      rsp_type r;
      r.out_byte  = b;
      r.frame_end = fe;
      r.run_last  = rl;
      frame_bytes_due.push_back(r);
   endfunction

   function automatic void close_frame();
      emit(sum_a, 1'b0, 1'b0);
      emit(sum_b, 1'b1, 1'b1);
      frame_open = 1'b0;
   endfunction

   function automatic int encode_item(req_type it);
      int n;
      n = frame_bytes_due.size();
      if (it.command == CMD_START) begin
         sum_a = '0;
         sum_b = '0;
         fold(it.msg_class);
         fold(it.msg_id);
         fold(it.payload_length[7:0]);
         fold(it.payload_length[15:8]);
         emit(sync_first, 1'b0, 1'b0);
         emit(sync_second, 1'b0, 1'b0);
         emit(it.msg_class, 1'b0, 1'b0);
         emit(it.msg_id, 1'b0, 1'b0);
         emit(it.payload_length[7:0], 1'b0, 1'b0);
         emit(it.payload_length[15:8], 1'b0, it.payload_length != '0);
         bytes_left = it.payload_length;
         frame_open = 1'b1;
         if (it.payload_length == '0) close_frame();
      end else if (frame_open && bytes_left != '0) begin
         fold(it.data_byte);
         bytes_left = bytes_left - 1'b1;
         emit(it.data_byte, 1'b0, bytes_left != '0);
         if (bytes_left == '0) close_frame();
      end else begin
         frame_open = 1'b0;
      end
      return frame_bytes_due.size() - n;
   endfunction

   function automatic req_type rand_req(logic cmd);
      req_type r;
      r.command        = cmd;
      r.msg_class      = ByteW'($urandom);
      r.msg_id         = ByteW'($urandom);
      r.payload_length = LenW'($urandom);
      r.data_byte      = ByteW'($urandom);
      return r;
   endfunction

   task automatic send_item(input req_type it, output int n);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      n = encode_item(it);
   endtask

   task automatic send_start(input logic [ByteW-1:0] cls, input logic [ByteW-1:0] id,
                             input logic [LenW-1:0] len);
      req_type r;
      int n;
      r = rand_req(CMD_START);
      r.msg_class      = cls;
      r.msg_id         = id;
      r.payload_length = len;
      send_item(r, n);
   endtask

   task automatic send_payload(input logic [ByteW-1:0] d);
      req_type r;
      int n;
      r = rand_req(CMD_PAYLOAD);
      r.data_byte = d;
      send_item(r, n);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frame_bytes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_sync(input logic [ByteW-1:0] a, input logic [ByteW-1:0] b);
      csr_valid <= 1'b1;
      csr_index <= CSR_SYNC_FIRST;
      csr_wdata <= a;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sync_first = a;
      csr_index <= CSR_SYNC_SECOND;
      csr_wdata <= b;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sync_second = b;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_header_and_abort();
      send_start(8'hFF, 8'h00, 16'h0000);
      send_payload(8'h5A);
      send_start(8'h00, 8'hFF, 16'h0003);
      send_payload(8'hFF);
      send_payload(8'h00);
      send_payload(8'h81);
      send_start(8'h12, 8'h34, 16'hFFFF);
      send_payload(8'hAA);
      send_start(8'hA5, 8'h5A, 16'h0001);
      send_payload(8'h7E);
      send_payload(8'h01);
      send_start(8'h01, 8'h02, 16'h0100);
      send_payload(8'h33);
      send_start(8'h06, 8'h01, 16'h8000);
      send_start(8'h0A, 8'h04, 16'h0000);
      send_payload(8'hC3);
   endtask

   task automatic test_long_frame();
      send_start(ByteW'($urandom), ByteW'($urandom), 16'd260);
      repeat (260) send_payload(ByteW'($urandom));
   endtask

   task automatic test_sync_registers();
      wait_drained();
      set_sync(8'h00, 8'hFF);
      send_start(ByteW'($urandom), ByteW'($urandom), 16'h0000);
      send_start(ByteW'($urandom), ByteW'($urandom), 16'h0002);
      send_payload(ByteW'($urandom));
      send_payload(ByteW'($urandom));
      wait_drained();
      set_sync(8'hFF, 8'h00);
      send_start(ByteW'($urandom), ByteW'($urandom), 16'h0000);
      send_start(ByteW'($urandom), ByteW'($urandom), 16'h0001);
      send_payload(ByteW'($urandom));
   endtask

   task automatic test_random_frames(input int target);
      int sent;
      int pick;
      int n;
      int body;
      req_type r;
      sent = 0;
      while (sent < target) begin
         pick = $urandom_range(99);
         if (pick < 4) begin
            wait_drained();
         end else if (pick < 14) begin
            send_item(rand_req(CMD_PAYLOAD), n);
            if (n > 0) sent++;
         end else begin
            r = rand_req(CMD_START);
            pick = $urandom_range(99);
            if (pick < 12) r.payload_length = '0;
            else if (pick < 96) r.payload_length = LenW'($urandom_range(1, 12));
            body = int'(r.payload_length);
            if (body > 12) body = int'($urandom_range(0, 6));
            else if (body > 0 && $urandom_range(99) < 10)
               body = int'($urandom_range(0, body - 1));
            send_item(r, n);
            sent++;
            repeat (body) begin
               send_item(rand_req(CMD_PAYLOAD), n);
               sent++;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (frame_bytes_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: expected none, actual byte %h end %b last %b",
                     $time, rsp_data.out_byte, rsp_data.frame_end, rsp_data.run_last);
         end else begin
            want = frame_bytes_due.pop_front();
            if (rsp_data.out_byte !== want.out_byte || rsp_data.frame_end !== want.frame_end
                || rsp_data.run_last !== want.run_last) begin
               errors++;
               $display("%0t: mismatch: expected byte %h end %b last %b, actual byte %h end %b last %b",
                        $time, want.out_byte, want.frame_end, want.run_last,
                        rsp_data.out_byte, rsp_data.frame_end, rsp_data.run_last);
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      rsp_ready <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_header_and_abort();
      test_long_frame();
      test_sync_registers();
      test_random_frames(7);

      wait_drained();
      send_idle_pct = 54;
      rsp_idle_pct  = 19;
      set_sync(ByteW'($urandom), ByteW'($urandom));
      test_random_frames(7);

      wait_drained();
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      set_sync(SYNC_FIRST_RESET, SYNC_SECOND_RESET);
      test_random_frames(8);

      wait_drained();
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
